FILE: hw/rtl/rrv_pkg.sv
// shared constants and types for the running return volatility block
package rrv_pkg;

  localparam int MaxSamples = 65536;
  localparam int CntW = 17;
  localparam int ScaleShift = 24;
  localparam logic [8:0] AnnualPeriods = 9'd252;
  localparam logic [CntW-1:0] LenReset = 17'd252;

  // divider request from the sequencer
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } rrv_div_req_t;

  // divider response
  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } rrv_div_rsp_t;

endpackage

FILE: hw/rtl/running_return_volatility.sv
// top level: compounded return and running annualized volatility
//
//  channel   signals                                         direction
//  input     in_valid, in_ready, sample_return, series_start  in
//  output    out_valid, out_ready, cum_return,
//            volatility, volatility_valid                     out
//  config    cfg_we, cfg_data (series_length)                 in
//
// one sample at a time; the result registers load after one 64-step divider
// pass for the mean on the first sample of a series, and otherwise after
// three 64-step passes of the shared bit-serial divider (mean update,
// M2/(n-1), v1/(N-1)) plus a 40-step square root
// in_ready stays low while a sample is in work; a finished result waits in the
// output registers and holds the sequencer until the previous one is taken
// reset clears all running statistics and sets series_length to 252
module running_return_volatility (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  sample_return,
  input  logic                series_start,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  cum_return,
  output logic [39:0]         volatility,
  output logic                volatility_valid,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_CUM   = 4'd2;
  localparam logic [3:0] S_MDIV  = 4'd3;
  localparam logic [3:0] S_MUPD  = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_M2    = 4'd6;
  localparam logic [3:0] S_V1    = 4'd7;
  localparam logic [3:0] S_V2    = 4'd8;
  localparam logic [3:0] S_VAR   = 4'd9;
  localparam logic [3:0] S_ROOT  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_SQ2   = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0]          state;
  logic [rrv_pkg::CntW-1:0] series_length;
  logic signed [47:0]  cum;
  logic signed [63:0]  mean;
  logic [63:0]         m2;
  logic [rrv_pkg::CntW-1:0] cnt;
  logic signed [31:0]  r;
  logic [63:0]         pm;
  logic signed [63:0]  d;
  logic signed [63:0]  e;
  logic [63:0]         dmag;
  logic [63:0]         emag;
  logic [127:0]        prod;
  logic [63:0]         v1;
  logic [63:0]         var_q;
  logic                div_neg;
  rrv_pkg::rrv_div_req_t div_req;
  rrv_pkg::rrv_div_rsp_t div_rsp;
  logic                sq_start;
  logic [72:0]         sq_in;
  logic                sq_done;
  logic [39:0]         sq_root;
  logic [63:0]         pp_a;
  logic [63:0]         pp_b;
  logic [63:0]         pp_c;
  logic [63:0]         pp_d;
  logic                emit;

  rrv_divider u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  rrv_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
                   .done(sq_done), .root(sq_root));

  assign in_ready = (state == S_IDLE);

  // result registers load once the previous result is gone or leaving
  assign emit = (state == S_EMIT) && (!out_valid || out_ready);

  // magnitudes of signed values
  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'(-v) : 64'(v);
  endfunction

  logic [47:0] cm;
  logic [31:0] rm;
  logic signed [63:0] csum;
  logic [64:0] m2_sum;
  logic [63:0] m_inc;
  logic [64:0] var_sum;

  always_comb begin
    cm = 48'(mag(64'(cum)));
    rm = 32'(mag(64'(r)));
    csum = 64'(cum) + 64'(r) + (((cum < 0) != (r < 0)) ? -$signed(pm) : $signed(pm));
    if (prod[127:112] != 16'd0) m_inc = '1;
    else m_inc = prod[111:48] + 64'(prod[47]);
    if (prod[127:112] == 16'd0 && prod[111:47] == {65{1'b1}}) m_inc = '1;
    m2_sum  = 65'(m2) + 65'(m_inc);
    var_sum = 65'(v1) + 65'(div_rsp.quotient);
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      series_length <= rrv_pkg::LenReset;
      cum           <= '0;
      mean          <= '0;
      m2            <= '0;
      cnt           <= '0;
      div_req.start <= 1'b0;
      sq_start      <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      sq_start      <= 1'b0;
      if (cfg_we) series_length <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            r <= sample_return;
            if (series_start) begin
              cum <= '0; mean <= '0; m2 <= '0;
              cnt <= 17'd1;
            end else if (cnt != 17'(rrv_pkg::MaxSamples)) begin
              cnt <= cnt + 17'd1;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // 24x32 and 24x32 partial products of |c|*|r|
          pp_a  <= 64'(cm[47:24]) * 64'(rm);
          pp_b  <= 64'(cm[23:0]) * 64'(rm);
          d     <= (64'(r) <<< rrv_pkg::ScaleShift) - mean;
          state <= S_CUM;
        end
        S_CUM: begin
          pm <= pp_a + ((pp_b + 64'h80_0000) >> rrv_pkg::ScaleShift);
          state <= S_MDIV;
          div_req.start    <= 1'b1;
          div_req.dividend <= mag(d);
          div_req.divisor  <= 64'(cnt);
          div_neg          <= d[63];
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            // compounded return, saturated to 48 bits
            if (csum > 64'sd140737488355327) cum <= 48'sh7FFF_FFFF_FFFF;
            else if (csum < -64'sd140737488355328) cum <= 48'sh8000_0000_0000;
            else cum <= csum[47:0];
            mean  <= mean + (div_neg ? -64'(div_rsp.quotient)
                                     : 64'(div_rsp.quotient));
            state <= S_MUPD;
          end
        end
        S_MUPD: begin
          e     <= (64'(r) <<< rrv_pkg::ScaleShift) - mean;
          dmag  <= mag(d);
          state <= S_SQ;
        end
        S_SQ: begin
          emag <= mag(e);
          state <= S_SQ2;
        end
        S_SQ2: begin
          // 32x32 partial products of |d|*|e|
          pp_a  <= 64'(dmag[31:0]) * 64'(emag[31:0]);
          pp_b  <= 64'(dmag[31:0]) * 64'(emag[63:32]);
          pp_c  <= 64'(dmag[63:32]) * 64'(emag[31:0]);
          pp_d  <= 64'(dmag[63:32]) * 64'(emag[63:32]);
          prod  <= '0;
          state <= S_M2;
        end
        S_M2: begin
          if (prod == '0 && !sq_done) begin
            prod <= {pp_d, 64'd0} + {32'd0, pp_b, 32'd0} + {32'd0, pp_c, 32'd0}
                    + {64'd0, pp_a} + 128'd0;
            if ({pp_d, pp_a, pp_b, pp_c} == '0) begin
              state <= S_V1;
            end
          end else begin
            state <= S_V1;
          end
          if (prod != '0) begin
            if (d != 0 && e != 0 && (d[63] != e[63]))
              m2 <= (m2 > m_inc) ? m2 - m_inc : 64'd0;
            else
              m2 <= m2_sum[64] ? '1 : m2_sum[63:0];
          end
        end
        S_V1: begin
          if (cnt < 17'd2) begin
            state <= S_EMIT;
          end else if (!div_req.start && !div_rsp.done) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= m2;
            div_req.divisor  <= 64'(cnt - 17'd1);
            state            <= S_V2;
          end
        end
        S_V2: begin
          if (div_rsp.done) begin
            v1 <= div_rsp.quotient;
            div_req.start    <= 1'b1;
            div_req.dividend <= div_rsp.quotient;
            div_req.divisor  <= (series_length < 17'd2) ? 64'd1
                                : 64'(series_length - 17'd1);
            state <= S_VAR;
          end
        end
        S_VAR: begin
          if (div_rsp.done) begin
            var_q <= var_sum[64] ? '1 : var_sum[63:0];
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          sq_start <= 1'b1;
          sq_in    <= 73'(var_q) * 73'(rrv_pkg::AnnualPeriods);
          state    <= S_OUT;
        end
        S_OUT: begin
          if (sq_done) state <= S_EMIT;
        end
        S_EMIT: begin
          // first sample of a series carries no volatility
          if (emit) begin
            volatility       <= (cnt < 17'd2) ? 40'd0 : sq_root;
            volatility_valid <= (cnt >= 17'd2);
            cum_return       <= cum;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL) else $error("accept not started");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cum_return) && $stable(volatility))
    else $error("result changed while waiting");
  a_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && volatility_valid |-> cnt >= 17'd2)
    else $error("valid flag with short series");

endmodule

FILE: hw/rtl/rrv_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module rrv_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  rrv_pkg::rrv_div_req_t req,
  output rrv_pkg::rrv_div_rsp_t rsp
);

  logic [63:0] quo;
  logic [64:0] rem;
  logic [63:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic [64:0] shifted;

  // shift in next dividend bit and try a subtract
  always_comb begin
    shifted = {rem[63:0], quo[63]};
    trial   = shifted - {1'b0, dsr};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp = '{done: done, quotient: quo};

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !busy) else $error("divider still busy at done");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(req.start) |-> !rsp.done || $past(busy))
    else $error("divider done while idle");

endmodule

FILE: hw/rtl/rrv_sqrt.sv
// bit-serial integer square root, one result bit per cycle
module rrv_sqrt (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [72:0]  radicand,
  output logic         done,
  output logic [39:0]  root
);

  logic [79:0] rad;
  logic [41:0] rem;
  logic [39:0] res;
  logic [5:0]  cnt;
  logic        busy;
  logic [41:0] sh;
  logic [41:0] trial;

  // restoring step on two radicand bits
  always_comb begin
    sh    = {rem[39:0], rad[79:78]};
    trial = sh - {res, 2'b01};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd39) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad <= {7'd0, radicand};
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= {rad[77:0], 2'b00};
      if (!trial[41]) begin
        rem <= trial;
        res <= {res[38:0], 1'b1};
      end else begin
        rem <= sh;
        res <= {res[38:0], 1'b0};
      end
    end
  end

  assign root = res;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("sqrt done held");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("sqrt done without busy");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("sqrt busy at done");

endmodule
